@@ sv/ric_pkg.sv @@
package ric_pkg;

   localparam int CHANNELS_DEFAULT  = 8;
   localparam int LOG_DEPTH_DEFAULT = 32;

   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 72;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int FILL_OUT_W  = 6;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_BOOT_LOCK  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GUARD_XTRA = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GUARD_CHAN = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_LOW = 2'd3;

   // reset values of the configuration registers
   localparam logic [31:0] BOOT_LOCK_RESET  = 32'd5000;
   localparam logic [31:0] GUARD_XTRA_RESET = 32'd10000;
   localparam logic [2:0]  GUARD_CHAN_RESET = 3'd0;
   localparam logic        ACTIVE_LOW_RESET = 1'b1;

   typedef enum logic [1:0] {
      CMD_TICK   = 2'd0,
      CMD_SET    = 2'd1,
      CMD_MANUAL = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_BOOT   = 2'd0,
      MODE_ARMED  = 2'd1,
      MODE_MANUAL = 2'd2
   } mode_type;

   // request item, packed lowest field last
   typedef struct packed {
      logic       enable;
      logic [3:0] requester;
      logic       turn_on;
      logic [2:0] channel;
   } req_item_type;

   // result item, packed lowest field last
   typedef struct packed {
      logic [FILL_OUT_W-1:0] log_fill;
      logic [31:0]           log_time;
      logic [3:0]            log_origin;
      logic                  log_state;
      logic [2:0]            log_channel;
      logic                  log_valid;
      logic [1:0]            mode;
      logic                  pins_released;
      logic [7:0]            pin_levels;
      logic [7:0]            relay_states;
      logic                  accepted;
   } rsp_item_type;

   typedef struct packed {
      logic [31:0] boot_hold_ms;
      logic [31:0] guard_extra_ms;
      logic [2:0]  guarded_channel;
      logic        active_low;
   } cfg_type;

   typedef struct packed {
      mode_type    mode;
      logic [31:0] elapsed_ms;
      logic [7:0]  relay_on;
   } state_type;

endpackage

@@ sv/ric_state.sv @@
module ric_state import ric_pkg::*; #(
   parameter int CHANNELS  = CHANNELS_DEFAULT,
   parameter int LOG_DEPTH = LOG_DEPTH_DEFAULT,
   localparam int CNT_W    = $clog2(LOG_DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             update,
   input  state_type        state_in,
   input  logic [CNT_W-1:0] fill_in,
   output state_type        state_ff,
   output logic [CNT_W-1:0] fill_ff
);

   // boot records, one per channel, already sit in the log
   localparam int FILL_RESET = (CHANNELS < LOG_DEPTH) ? CHANNELS : LOG_DEPTH;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode       <= MODE_BOOT;
         state_ff.elapsed_ms <= '0;
         state_ff.relay_on   <= '0;
         fill_ff             <= CNT_W'(FILL_RESET);
      end else if (update) begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
      end
   end

endmodule

@@ sv/ric_step.sv @@
module ric_step import ric_pkg::*; #(
   parameter int CHANNELS  = CHANNELS_DEFAULT,
   parameter int LOG_DEPTH = LOG_DEPTH_DEFAULT,
   localparam int CNT_W    = $clog2(LOG_DEPTH + 1)
) (
   input  logic [1:0]       cmd,
   input  req_item_type     item,
   input  cfg_type          cfg,
   input  state_type        state_cur,
   input  logic [CNT_W-1:0] fill_cur,
   output state_type        state_in,
   output logic [CNT_W-1:0] fill_in,
   output rsp_item_type     result
);

   localparam logic [7:0] CHAN_MASK = 8'((9'(1) << CHANNELS) - 9'(1));

   logic [31:0]          guard_end;
   logic [31:0]          tick_ms;
   logic                 chan_ok;
   logic                 cur_bit;
   logic                 acc;
   logic                 lv;
   logic                 lst;
   logic [3:0]           lor;
   logic                 released;
   logic [CNT_W+FILL_OUT_W-1:0] fill_ext;

   assign guard_end = cfg.boot_hold_ms + cfg.guard_extra_ms;
   assign tick_ms   = state_cur.elapsed_ms + 32'd1;
   assign chan_ok   = {1'b0, item.channel} < 4'(CHANNELS);
   assign cur_bit   = state_cur.relay_on[item.channel];

   always_comb begin
      state_in = state_cur;
      acc      = 1'b1;
      lv       = 1'b0;
      lst      = 1'b0;
      lor      = '0;
      unique case (cmd)
         CMD_TICK: begin
            state_in.elapsed_ms = tick_ms;
            if (state_cur.mode == MODE_BOOT && tick_ms >= cfg.boot_hold_ms) begin
               state_in.mode = MODE_ARMED;
            end
         end
         CMD_SET: begin
            priority if (!chan_ok) begin
               acc = 1'b0;
            end else if (state_cur.mode == MODE_BOOT) begin
               // refused during boot lock, logged with boot origin
               acc = 1'b0;
               lv  = 1'b1;
               lst = cur_bit;
            end else if (state_cur.mode == MODE_MANUAL) begin
               acc = 1'b0;
            end else if (item.channel == cfg.guarded_channel &&
                         state_cur.elapsed_ms < guard_end) begin
               acc = 1'b0;
            end else if (cur_bit != item.turn_on) begin
               state_in.relay_on[item.channel] = item.turn_on;
               lv  = 1'b1;
               lst = item.turn_on;
               lor = item.requester;
            end else begin
               acc = 1'b1;
            end
         end
         CMD_MANUAL: begin
            if (item.enable != (state_cur.mode == MODE_MANUAL)) begin
               state_in.mode = item.enable ? MODE_MANUAL : MODE_ARMED;
            end
         end
         default: begin
            acc = 1'b0;
         end
      endcase
      state_in.relay_on = state_in.relay_on & CHAN_MASK;
   end

   // saturating fill count of the log ring
   assign fill_in  = (lv && fill_cur < CNT_W'(LOG_DEPTH)) ? fill_cur + CNT_W'(1) : fill_cur;
   assign fill_ext = (CNT_W + FILL_OUT_W)'(fill_in);

   assign released = (state_in.mode == MODE_MANUAL);

   always_comb begin
      result.accepted      = acc;
      result.relay_states  = state_in.relay_on;
      result.pin_levels    = released ? 8'd0
                             : ((state_in.relay_on ^ {8{cfg.active_low}}) & CHAN_MASK);
      result.pins_released = released;
      result.mode          = state_in.mode;
      result.log_valid     = lv;
      result.log_channel   = lv ? item.channel : 3'd0;
      result.log_state     = lst;
      result.log_origin    = lor;
      result.log_time      = lv ? state_cur.elapsed_ms : 32'd0;
      result.log_fill      = fill_ext[FILL_OUT_W-1:0];
   end

endmodule

@@ sv/relay_interlock_controller.sv @@
// relay interlock controller: eight relay channels with boot lock, armed and
// manual modes
//
// req channel: one item per command; req_tuser carries the command (tick,
// set relay, manual request), req_tdata the set and manual arguments.
// rsp channel: exactly one result item per request item, in order, giving
// the set outcome, relay and pin state, mode and the log record written.
// csr port: plain write port; the user must write it only while no item is in flight, the block does not check.
//
// path: an accepted item sits in the input register, and its result moves
// on through the result register onto rsp once the result slot is free.
// throughput: one item per clock while rsp is not held off; the state
// registers close their update loop as each item moves on.
//
// reset: boot locked, elapsed time zero, all relays off, log fill holds one
// boot record per channel, configuration back to its defaults.
// stall: while rsp is held off the result register keeps its item and the
// input register can still take one more; req_tready drops only when both
// are full.
module relay_interlock_controller import ric_pkg::*; #(
   parameter int CHANNELS  = CHANNELS_DEFAULT,
   parameter int LOG_DEPTH = LOG_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // channel, turn_on, requester, enable, zero fill
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // cmd
   input  logic [1:0]             req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // accepted, relay_states, pin_levels, pins_released, mode, log_valid,
   // log_channel, log_state, log_origin, log_time, log_fill, zero fill
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CNT_W = $clog2(LOG_DEPTH + 1);

   cfg_type          cfg_ff;
   logic             in_valid_ff;
   req_item_type     in_item_ff;
   logic [1:0]       in_cmd_ff;
   logic             rsp_valid_ff;
   rsp_item_type     rsp_item_ff;
   logic             advance;
   state_type        state_cur;
   state_type        state_in;
   logic [CNT_W-1:0] fill_cur;
   logic [CNT_W-1:0] fill_in;
   rsp_item_type     result;

   // item in the input register moves on once the result slot frees up
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.boot_hold_ms    <= BOOT_LOCK_RESET;
         cfg_ff.guard_extra_ms  <= GUARD_XTRA_RESET;
         cfg_ff.guarded_channel <= GUARD_CHAN_RESET;
         cfg_ff.active_low      <= ACTIVE_LOW_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BOOT_LOCK:  cfg_ff.boot_hold_ms    <= csr_wdata;
            CSR_GUARD_XTRA: cfg_ff.guard_extra_ms  <= csr_wdata;
            CSR_GUARD_CHAN: cfg_ff.guarded_channel <= csr_wdata[2:0];
            CSR_ACTIVE_LOW: cfg_ff.active_low      <= csr_wdata[0];
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff <= req_tdata[$bits(req_item_type)-1:0];
         in_cmd_ff  <= req_tuser;
      end
   end

   // next state and result for the item in the input register
   ric_step #(
      .CHANNELS  (CHANNELS),
      .LOG_DEPTH (LOG_DEPTH)
   ) u_step (
      .cmd       (in_cmd_ff),
      .item      (in_item_ff),
      .cfg       (cfg_ff),
      .state_cur (state_cur),
      .fill_cur  (fill_cur),
      .state_in  (state_in),
      .fill_in   (fill_in),
      .result    (result)
   );

   // mode, elapsed time, relays and log fill, committed as the item moves on
   ric_state #(
      .CHANNELS  (CHANNELS),
      .LOG_DEPTH (LOG_DEPTH)
   ) u_state (
      .clock    (clock),
      .reset    (reset),
      .update   (advance),
      .state_in (state_in),
      .fill_in  (fill_in),
      .state_ff (state_cur),
      .fill_ff  (fill_cur)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_tready) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_item_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_item_ff);

endmodule

@@ sv/ric_checker.sv @@
module ric_checker import ric_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   rsp_item_type rsp;

   assign rsp = rsp_tdata[$bits(rsp_item_type)-1:0];

   // no result appears right out of reset
   a_reset_quiet: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // released pins go with manual mode and read zero
   a_release: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp.pins_released == (rsp.mode == MODE_MANUAL)) &&
                     (!rsp.pins_released || rsp.pin_levels == 8'd0))
      else $error("pin release does not match mode");

   // record fields are zero when nothing was logged
   a_no_log: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp.log_valid |-> rsp.log_channel == 3'd0 && !rsp.log_state &&
                                       rsp.log_origin == 4'd0 && rsp.log_time == 32'd0)
      else $error("log fields set without a record");

   // a refused set that logs must carry the boot origin, zero
   a_log_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.log_valid && !rsp.accepted |-> rsp.log_origin == 4'd0)
      else $error("refused set logged with a requester origin");

endmodule

bind relay_interlock_controller ric_checker u_ric_checker (.*);

@@ bench/relay_interlock_controller_test.sv @@
`timescale 1ns / 1ps

module relay_interlock_controller_test;
   import ric_pkg::*;

   // cmd code 3 has no meaning, the block must refuse it and change nothing
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   // cycles with no handshake on either side before the run is abandoned
   localparam int IDLE_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 8;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_ITEMS = 160;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // channel, turn_on, requester, enable, zero fill
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   // cmd
   logic [1:0]             req_tuser = CMD_TICK;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // accepted, relay_states, pin_levels, pins_released, mode, log_valid,
   // log_channel, log_state, log_origin, log_time, log_fill, zero fill
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_BOOT_LOCK;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   relay_interlock_controller uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // shadow of the interlock: mode, elapsed time, relay bits, log fill and
   // the configuration the block was last given
   mode_type    shadow_mode;
   logic [31:0] shadow_elapsed;
   logic [7:0]  shadow_relays;
   logic [5:0]  shadow_fill;
   cfg_type     shadow_cfg;

   // status items predicted at acceptance, oldest first
   rsp_item_type expected_status[$];
   rsp_item_type want_status, got_status;
   int           fail_count = 0;
   int           idle_cycles = 0;
   int           burst_left = 0;

   // receiver stall pattern
   int stall_style = 0;
   int stall_left = 0;

   // one log record into the ring; of the ring itself only the fill count is visible outside
   function automatic void note_log_write(inout rsp_item_type r, input logic [2:0] ch,
                                          input logic st, input logic [3:0] origin);
      r.log_valid   = 1'b1;
      r.log_channel = ch;
      r.log_state   = st;
      r.log_origin  = origin;
      r.log_time    = shadow_elapsed;
      if (shadow_fill < LOG_DEPTH_DEFAULT)
         shadow_fill++;
   endfunction

   // apply one command to the shadow state and return the status it gives
   function automatic rsp_item_type advance_interlock(input logic [1:0] cmd,
                                                      input req_item_type it);
      rsp_item_type r;
      logic [31:0]  guard_end;
      r = '0;
      r.accepted = 1'b1;
      guard_end = shadow_cfg.boot_hold_ms + shadow_cfg.guard_extra_ms;
      case (cmd)
         CMD_TICK: begin
            shadow_elapsed = shadow_elapsed + 32'd1;
            if (shadow_mode == MODE_BOOT && shadow_elapsed >= shadow_cfg.boot_hold_ms)
               shadow_mode = MODE_ARMED;
         end
         CMD_SET: begin
            if (shadow_mode == MODE_BOOT) begin
               // refused, but the attempt is logged with boot origin
               r.accepted = 1'b0;
               note_log_write(r, it.channel, shadow_relays[it.channel], 4'd0);
            end else if (shadow_mode == MODE_MANUAL) begin
               r.accepted = 1'b0;
            end else if (it.channel == shadow_cfg.guarded_channel &&
                         shadow_elapsed < guard_end) begin
               r.accepted = 1'b0;
            end else if (shadow_relays[it.channel] != it.turn_on) begin
               shadow_relays[it.channel] = it.turn_on;
               note_log_write(r, it.channel, it.turn_on, it.requester);
            end
         end
         CMD_MANUAL: begin
            // a request for the mode already in force does nothing
            if (it.enable != (shadow_mode == MODE_MANUAL))
               shadow_mode = it.enable ? MODE_MANUAL : MODE_ARMED;
         end
         default: r.accepted = 1'b0;
      endcase
      r.relay_states  = shadow_relays;
      r.pins_released = (shadow_mode == MODE_MANUAL);
      r.pin_levels    = r.pins_released ? 8'h00
                                        : shadow_relays ^ {8{shadow_cfg.active_low}};
      r.mode          = shadow_mode;
      r.log_fill      = shadow_fill;
      return r;
   endfunction

   function automatic req_item_type make_item(input logic [2:0] ch, input logic on,
                                              input logic [3:0] requester, input logic en);
      req_item_type it;
      it.channel   = ch;
      it.turn_on   = on;
      it.requester = requester;
      it.enable    = en;
      return it;
   endfunction

   // present one item and hold it until the block takes it
   task automatic send_item(input logic [1:0] cmd, input req_item_type it);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {{(REQ_TDATA_W - $bits(req_item_type)){1'b0}}, it};
      do
         @(posedge clock);
      while (!req_tready);
      expected_status.push_back(advance_interlock(cmd, it));
   endtask

   // same as send_item, but in bursts with random gaps between them
   task automatic send_paced(input logic [1:0] cmd, input req_item_type it);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = $urandom_range(0, 5);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      send_item(cmd, it);
   endtask

   // stop sending and let every outstanding status come back
   task automatic drain_status;
      req_tvalid <= 1'b0;
      while (expected_status.size() != 0)
         @(posedge clock);
      // covers the input and result registers
      repeat (2) @(posedge clock);
   endtask

   // write all four registers, one per cycle, while the block is idle
   task automatic load_config(input cfg_type c);
      csr_we    <= 1'b1;
      csr_index <= CSR_BOOT_LOCK;
      csr_wdata <= c.boot_hold_ms;
      @(posedge clock);
      csr_index <= CSR_GUARD_XTRA;
      csr_wdata <= c.guard_extra_ms;
      @(posedge clock);
      csr_index <= CSR_GUARD_CHAN;
      csr_wdata <= CSR_DATA_W'(c.guarded_channel);
      @(posedge clock);
      csr_index <= CSR_ACTIVE_LOW;
      csr_wdata <= CSR_DATA_W'(c.active_low);
      @(posedge clock);
      csr_we <= 1'b0;
      shadow_cfg = c;
   endtask

   // boot locked at defaults, then zero boot lock, manual entry from boot
   // locked and the way out of it
   task automatic test_boot_lock;
      cfg_type c;
      send_item(CMD_TICK, make_item(3'd0, 1'b0, 4'd1, 1'b0));
      // refused while boot locked, logged with boot origin
      send_item(CMD_SET, make_item(3'd3, 1'b1, 4'd5, 1'b0));
      send_item(CMD_SET, make_item(3'd7, 1'b1, 4'd0, 1'b1));
      send_item(CMD_UNUSED, make_item(3'd5, 1'b1, 4'd15, 1'b1));
      // leave manual while not manual: nothing happens
      send_item(CMD_MANUAL, make_item(3'd0, 1'b0, 4'd1, 1'b0));
      drain_status();
      // zero boot lock does not arm by itself, only a tick would
      c = '{boot_hold_ms: 32'd0, guard_extra_ms: GUARD_XTRA_RESET,
            guarded_channel: GUARD_CHAN_RESET, active_low: ACTIVE_LOW_RESET};
      load_config(c);
      send_item(CMD_SET, make_item(3'd0, 1'b1, 4'd9, 1'b0));
      send_item(CMD_MANUAL, make_item(3'd0, 1'b0, 4'd1, 1'b1));
      // a tick in manual mode must not arm
      send_item(CMD_TICK, make_item(3'd7, 1'b1, 4'd15, 1'b1));
      send_item(CMD_SET, make_item(3'd2, 1'b1, 4'd3, 1'b1));
      send_item(CMD_MANUAL, make_item(3'd1, 1'b1, 4'd2, 1'b1));
      // leaving manual arms, even though it was entered from boot locked
      send_item(CMD_MANUAL, make_item(3'd0, 1'b0, 4'd1, 1'b0));
      drain_status();
   endtask

   // armed: guard on the guarded channel, unchanged sets, requester zero,
   // guard sum wrapping and both pin polarities
   task automatic test_armed_sets;
      cfg_type c;
      // guard ends at 10000, far away
      send_item(CMD_SET, make_item(3'd0, 1'b1, 4'd15, 1'b0));
      send_item(CMD_SET, make_item(3'd1, 1'b1, 4'd1, 1'b0));
      send_item(CMD_SET, make_item(3'd1, 1'b1, 4'd2, 1'b1));
      send_item(CMD_SET, make_item(3'd7, 1'b1, 4'd0, 1'b0));
      send_item(CMD_SET, make_item(3'd1, 1'b0, 4'd15, 1'b1));
      drain_status();
      // sum wraps to all ones minus one: the guarded channel stays locked
      c = '{boot_hold_ms: 32'hFFFF_FFFF, guard_extra_ms: 32'hFFFF_FFFF,
            guarded_channel: 3'd7, active_low: 1'b0};
      load_config(c);
      send_item(CMD_SET, make_item(3'd7, 1'b0, 4'd4, 1'b0));
      send_item(CMD_SET, make_item(3'd0, 1'b1, 4'd6, 1'b0));
      send_item(CMD_TICK, make_item(3'd0, 1'b0, 4'd0, 1'b0));
      drain_status();
      // sum wraps to zero: no guard at all
      c = '{boot_hold_ms: 32'hFFFF_FFFF, guard_extra_ms: 32'd1,
            guarded_channel: 3'd7, active_low: 1'b1};
      load_config(c);
      send_item(CMD_SET, make_item(3'd7, 1'b0, 4'd8, 1'b0));
      send_item(CMD_SET, make_item(3'd6, 1'b1, 4'd10, 1'b1));
      drain_status();
   endtask

   // phases of random traffic, each with its own configuration; in most random
   // phases the guard end is placed just ahead of the elapsed time to expire mid phase
   task automatic test_random_traffic;
      cfg_type      c;
      req_item_type it;
      logic [1:0]   cmd;
      logic [31:0]  guard_end;
      int           pick;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         guard_end = shadow_elapsed + $urandom_range(0, 80);
         case (phase)
            0: c = '{boot_hold_ms: 32'd0, guard_extra_ms: 32'd0,
                     guarded_channel: 3'd0, active_low: 1'b0};
            1: c = '{boot_hold_ms: 32'hFFFF_FFFF, guard_extra_ms: 32'hFFFF_FFFF,
                     guarded_channel: 3'd7, active_low: 1'b1};
            default: begin
               c.boot_hold_ms    = $urandom;
               c.guarded_channel = $urandom_range(0, 7);
               c.active_low      = phase[0];
               if (phase % 4 == 3)
                  c.guard_extra_ms = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
               else
                  c.guard_extra_ms = guard_end - c.boot_hold_ms;
            end
         endcase
         load_config(c);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            it = req_item_type'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
               cmd = CMD_TICK;
            end else if (pick < 85) begin
               cmd = CMD_SET;
            end else if (pick < 96) begin
               // lean toward leaving manual so sets get through
               cmd = CMD_MANUAL;
               it.enable = ($urandom_range(0, 3) == 0);
            end else begin
               cmd = CMD_UNUSED;
            end
            send_paced(cmd, it);
         end
         drain_status();
      end
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endtask

   // result checker: every accepted status against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_status.size() == 0) begin
            $error("status item %h arrived with nothing outstanding", rsp_tdata);
            fail_count++;
         end else begin
            want_status = expected_status.pop_front();
            got_status  = rsp_item_type'(rsp_tdata[$bits(rsp_item_type)-1:0]);
            compare_field("accepted", want_status.accepted, got_status.accepted);
            compare_field("relay_states", want_status.relay_states, got_status.relay_states);
            compare_field("pin_levels", want_status.pin_levels, got_status.pin_levels);
            compare_field("pins_released", want_status.pins_released,
                          got_status.pins_released);
            compare_field("mode", want_status.mode, got_status.mode);
            compare_field("log_valid", want_status.log_valid, got_status.log_valid);
            compare_field("log_channel", want_status.log_channel, got_status.log_channel);
            compare_field("log_state", want_status.log_state, got_status.log_state);
            compare_field("log_origin", want_status.log_origin, got_status.log_origin);
            compare_field("log_time", want_status.log_time, got_status.log_time);
            compare_field("log_fill", want_status.log_fill, got_status.log_fill);
         end
      end
   end

   // receiver backpressure: styles picked at random, from always ready
   // through light and heavy stalls to solid hold-off stretches
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_style = $urandom_range(0, 3);
         stall_left  = (stall_style == 3) ? $urandom_range(1, 12) : $urandom_range(8, 64);
      end else begin
         stall_left--;
      end
      case (stall_style)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2: rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= 1'b0;
      endcase
   end

   // watchdog: cycles with no item moving on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("relay_interlock_controller verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      // shadow starts where the block comes out of reset: one boot record
      // per channel already in the log
      shadow_mode    = MODE_BOOT;
      shadow_elapsed = '0;
      shadow_relays  = '0;
      shadow_fill    = CHANNELS_DEFAULT;
      shadow_cfg     = '{boot_hold_ms: BOOT_LOCK_RESET, guard_extra_ms: GUARD_XTRA_RESET,
                         guarded_channel: GUARD_CHAN_RESET, active_low: ACTIVE_LOW_RESET};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_boot_lock();
      test_armed_sets();
      test_random_traffic();

      // everything is drained by the last phase; give the pipe time to show
      // any stray status
      drain_status();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("relay_interlock_controller verification clean");
      else
         $display("relay_interlock_controller verification failed");
      $finish;
   end

endmodule

@@ filelist.f @@
sv/ric_pkg.sv
sv/ric_state.sv
sv/ric_step.sv
sv/relay_interlock_controller.sv
sv/ric_checker.sv
bench/relay_interlock_controller_test.sv
